// ===== design/ole_pkg.sv =====
// Shared types for the ordered list engine: beat payloads, opcodes,
// status codes, controller states and the controller/datapath link.
// No dependencies.
`default_nettype none

package ole_pkg;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_POP    = 2'd3
    } cmd_code_t;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_NOT_FOUND = 2'd1,
        STS_FULL      = 2'd2,
        STS_EMPTY     = 2'd3
    } status_code_t;

    typedef struct packed {
        cmd_code_t          command;
        logic signed [31:0] value;
    } item_t;

    typedef struct packed {
        status_code_t       status;
        logic               found;
        logic [6:0]         position;
        logic signed [31:0] popped_value;
        logic [6:0]         entry_count;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_SHIFT,
        ST_POP,
        ST_DONE
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic         load;        // latch input beat, clear result fields
        logic         push_write;  // write value at the front slot, bump count
        logic         rd_top;      // read front slot, point index at it
        logic         rd_prev;     // read slot below index, step index down
        logic         rd_next;     // read slot above index
        logic         shift_step;  // move read word down one slot, step up
        logic         dec_total;   // drop one entry from the count
        logic         set_status;
        status_code_t status_code;
        logic         set_found;
        logic         set_pos;
        logic         take_pop;
        logic         emit;        // load the output register
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        cmd_code_t cmd;
        logic      full;
        logic      empty;
        logic      match;       // read word equals the latched value
        logic      idx_zero;
        logic      has_after;   // index + 1 below count
        logic      has_after2;  // index + 2 below count
        logic      out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== design/ole_ctrl.sv =====
// Controller state machine of the ordered list engine.
// Depends on ole_pkg for states, opcodes and the command/status structs.
`default_nettype none

module ole_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  ole_pkg::dp_status_t st,
    output ole_pkg::ctrl_cmd_t  cmd
);
    import ole_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (st.cmd)
                    CMD_PUSH:
                    begin
                        state_next = ST_DONE;
                    end
                    CMD_POP:
                    begin
                        state_next = st.empty ? ST_DONE : ST_POP;
                    end
                    default:
                    begin
                        state_next = st.empty ? ST_DONE : ST_SCAN;
                    end
                endcase
            end
            ST_SCAN:
            begin
                if (st.match)
                begin
                    if (st.cmd == CMD_DELETE && st.has_after)
                    begin
                        state_next = ST_SHIFT;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else if (st.idx_zero)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SHIFT:
            begin
                if (!st.has_after2)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_POP:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (st.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd        = '0;
        item_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                cmd.load   = item_valid;
            end
            ST_EXEC:
            begin
                case (st.cmd)
                    CMD_PUSH:
                    begin
                        if (st.full)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = STS_FULL;
                        end
                        else
                        begin
                            cmd.push_write = 1'b1;
                        end
                    end
                    CMD_POP:
                    begin
                        if (st.empty)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = STS_EMPTY;
                        end
                        else
                        begin
                            cmd.rd_top    = 1'b1;
                            cmd.dec_total = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (st.empty)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = STS_NOT_FOUND;
                        end
                        else
                        begin
                            cmd.rd_top = 1'b1;
                        end
                    end
                endcase
            end
            ST_SCAN:
            begin
                if (st.match)
                begin
                    cmd.set_found = 1'b1;
                    if (st.cmd == CMD_SEARCH)
                    begin
                        cmd.set_pos = 1'b1;
                    end
                    else if (st.has_after)
                    begin
                        cmd.rd_next = 1'b1;
                    end
                    else
                    begin
                        // match at the front: nothing to close up
                        cmd.dec_total = 1'b1;
                    end
                end
                else if (st.idx_zero)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = STS_NOT_FOUND;
                end
                else
                begin
                    cmd.rd_prev = 1'b1;
                end
            end
            ST_SHIFT:
            begin
                cmd.shift_step = 1'b1;
                cmd.dec_total  = !st.has_after2;
            end
            ST_POP:
            begin
                cmd.take_pop = 1'b1;
            end
            ST_DONE:
            begin
                cmd.emit = st.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/ole_datapath.sv =====
// Datapath of the ordered list engine: entry memory, count, walk index,
// result fields and the output register. Depends on ole_pkg.
`default_nettype none

module ole_datapath #(
    parameter int LIST_DEPTH = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ole_pkg::item_t      item,
    input  ole_pkg::ctrl_cmd_t  cmd,
    output ole_pkg::dp_status_t st,
    output ole_pkg::result_t    result,
    output logic                result_valid,
    input  logic                result_ready
);
    import ole_pkg::*;

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int XW = CW + 7;
    localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

    // Entry memory: slot 0 is the back, slot count-1 the front
    logic [31:0] mem [LIST_DEPTH];

    logic [CW-1:0]      total_reg;
    logic [CW-1:0]      total_next;
    logic [AW-1:0]      idx_reg;
    logic [AW-1:0]      idx_next;
    cmd_code_t          cmd_reg;
    logic signed [31:0] val_reg;
    logic [31:0]        rd_data_reg;
    status_code_t       res_status_reg;
    logic               res_found_reg;
    logic [CW-1:0]      res_pos_reg;
    logic signed [31:0] res_pop_reg;
    result_t            out_reg;
    logic               out_valid_reg;
    logic               out_valid_next;

    logic [CW-1:0] top_w;
    logic [AW-1:0] top_idx;
    logic [CW:0]   total_ext;
    logic [CW:0]   idx_ext;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic [XW-1:0] cnt_ext;
    logic [XW-1:0] pos_ext;

    assign top_w     = total_reg - CW'(1);
    assign top_idx   = top_w[AW-1:0];
    assign total_ext = {1'b0, total_reg};
    assign idx_ext   = (CW + 1)'(idx_reg);

    // Status toward the controller
    always_comb
    begin
        st.cmd        = cmd_reg;
        st.full       = (total_reg == DEPTH_C);
        st.empty      = (total_reg == '0);
        st.match      = (rd_data_reg == val_reg);
        st.idx_zero   = (idx_reg == '0);
        st.has_after  = ((idx_ext + (CW + 1)'(1)) < total_ext);
        st.has_after2 = ((idx_ext + (CW + 1)'(2)) < total_ext);
        st.out_free   = !out_valid_reg || result_ready;
    end

    // Select read and write ports
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = idx_reg;
        if (cmd.rd_top)
        begin
            rd_en   = 1'b1;
            rd_addr = top_idx;
        end
        else if (cmd.rd_prev)
        begin
            rd_en   = 1'b1;
            rd_addr = idx_reg - AW'(1);
        end
        else if (cmd.rd_next)
        begin
            rd_en   = 1'b1;
            rd_addr = idx_reg + AW'(1);
        end
        else if (cmd.shift_step && st.has_after2)
        begin
            rd_en   = 1'b1;
            rd_addr = idx_reg + AW'(2);
        end

        wr_en   = cmd.push_write || cmd.shift_step;
        wr_addr = cmd.push_write ? total_reg[AW-1:0] : idx_reg;
        wr_data = cmd.push_write ? val_reg : rd_data_reg;
    end

    // Memory ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Count and walk index
    always_comb
    begin
        total_next = total_reg;
        if (cmd.push_write)
        begin
            total_next = total_reg + CW'(1);
        end
        else if (cmd.dec_total)
        begin
            total_next = total_reg - CW'(1);
        end

        idx_next = idx_reg;
        if (cmd.rd_top)
        begin
            idx_next = top_idx;
        end
        else if (cmd.rd_prev)
        begin
            idx_next = idx_reg - AW'(1);
        end
        else if (cmd.shift_step)
        begin
            idx_next = idx_reg + AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
        end
        else
        begin
            total_reg <= total_next;
        end
    end

    // Latched beat, walk index and result fields
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (cmd.load)
        begin
            cmd_reg        <= item.command;
            val_reg        <= item.value;
            res_status_reg <= STS_OK;
            res_found_reg  <= 1'b0;
            res_pos_reg    <= '0;
            res_pop_reg    <= '0;
        end
        else
        begin
            if (cmd.set_status)
            begin
                res_status_reg <= cmd.status_code;
            end
            if (cmd.set_found)
            begin
                res_found_reg <= 1'b1;
            end
            if (cmd.set_pos)
            begin
                res_pos_reg <= total_reg - CW'(idx_reg);
            end
            if (cmd.take_pop)
            begin
                res_pop_reg <= rd_data_reg;
            end
        end
    end

    // Mask count and position to the 7-bit result fields
    assign cnt_ext = XW'(total_reg);
    assign pos_ext = XW'(res_pos_reg);

    // Output register: hold the beat until taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_reg.status       <= res_status_reg;
            out_reg.found        <= res_found_reg;
            out_reg.position     <= pos_ext[6:0];
            out_reg.popped_value <= res_pop_reg;
            out_reg.entry_count  <= cnt_ext[6:0];
        end
    end

    assign result       = out_reg;
    assign result_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== design/ordered_list_engine.sv =====
// Top level of the ordered list engine: controller plus datapath.
// Depends on ole_pkg, ole_ctrl and ole_datapath.
//
// Bounded list of up to LIST_DEPTH signed 32-bit values, newest at the
// front, kept in a single memory with one read and one write port. One
// command beat is worked at a time and gives one result beat; the next
// command is taken while the previous result still waits in the output
// register. A search walks the entries from the front up to the match,
// or all of them on a miss; a delete walks the same way and, on a hit
// with newer entries above it, then closes up the gap. Push and pop need
// no walk. A result still held in the output register stalls the engine
// until it is taken, before the next result is loaded. The time per beat
// is set by the walk through the memory, one slot per cycle on its single
// read port, and for delete by the close-up pass that copies every newer
// entry down one slot. No clearing pass after reset: slots are only read
// below the entry count.
`default_nettype none

module ordered_list_engine #(
    parameter int LIST_DEPTH = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  ole_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output ole_pkg::result_t result
);
    import ole_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t st;

    ole_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .st         (st),
        .cmd        (cmd)
    );

    ole_datapath #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .st           (st),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

endmodule

`default_nettype wire

// ===== design/ole_checker.sv =====
// Port-level checks for the ordered list engine, bound to the top level.
// Depends on ole_pkg and ordered_list_engine.
`default_nettype none

module ole_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_ready,
    input logic             result_valid,
    input logic             result_ready,
    input ole_pkg::result_t result
);
    import ole_pkg::*;

    // A stalled result beat holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result beat changed while stalled");

    // One command at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("input taken again right after an accept");

    // A match is always reported with ok status
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.found |-> result.status == STS_OK)
        else $error("found set with non-ok status");

    // A position only comes with a match
    a_pos_found: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.position != 7'd0 |-> result.found)
        else $error("position without match");

    // An empty report leaves a count of zero
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == STS_EMPTY |-> result.entry_count == 7'd0)
        else $error("empty status with nonzero count");

endmodule

bind ordered_list_engine ole_checker u_ole_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

`default_nettype wire
